### sv/crv_pkg.sv
// shared types, constants and arctangent table for the cordic rotate/vector unit
package crv_pkg;

    // datapath geometry
    localparam int DATA_W      = 32;
    localparam int ITER_COUNT  = 16;
    localparam int TABLE_LEN   = 16;
    localparam int IDX_W       = $clog2(TABLE_LEN);
    localparam int ANGLE_SHIFT = 24;

    // io field widths
    localparam int KIND_W  = 2;
    localparam int COMP_W  = 16;
    localparam int ANGLE_W = 8;

    // gain removal: q = (|v| * 2^GAIN_PRESCALE) / GAIN_DIV by reciprocal multiply
    localparam int GAIN_DIV      = 1686;
    localparam int GAIN_PRESCALE = 10;
    localparam int GAIN_SHIFT    = 32;
    localparam int RECIP_W       = 32;
    localparam logic [RECIP_W-1:0] GAIN_RECIP =
        RECIP_W'((64'd1 << (GAIN_SHIFT + GAIN_PRESCALE)) / GAIN_DIV);
    // component magnitudes stay below 2^17 for 16-bit inputs
    localparam int MAG_W = 18;
    localparam int PROD_W = MAG_W + RECIP_W;
    localparam int REM_W  = MAG_W + GAIN_PRESCALE + 1;

    // percent scaling for sine and cosine
    localparam int PCT_SCALE = 100;
    localparam int PCT_K_W   = 8;
    localparam int PCT_SHIFT = 14;
    localparam int PCT_W     = COMP_W + PCT_K_W;

    // unit vector for the sine and cosine mode
    localparam logic [DATA_W-1:0] UNIT_X = 32'd16384;

    typedef enum logic [KIND_W-1:0] {
        KIND_ROTATE = 2'd0,
        KIND_VECTOR = 2'd1,
        KIND_TRIG   = 2'd2,
        KIND_NONE   = 2'd3
    } t_kind;

    // item state as it travels down the cell chain
    typedef struct packed {
        t_kind             kind;
        logic [DATA_W-1:0] x;
        logic [DATA_W-1:0] y;
        logic [DATA_W-1:0] z;
    } t_cordic_data;

    // arctan(2^-i) in degrees, scaled by 2^24
    function automatic logic [DATA_W-1:0] atan_arc(input logic [IDX_W-1:0] idx);
        logic [DATA_W-1:0] arc;
        unique case (idx)
            4'd0:  arc = 32'd754974720;
            4'd1:  arc = 32'd445687602;
            4'd2:  arc = 32'd235489088;
            4'd3:  arc = 32'd119537938;
            4'd4:  arc = 32'd60000934;
            4'd5:  arc = 32'd30029717;
            4'd6:  arc = 32'd15018523;
            4'd7:  arc = 32'd7509720;
            4'd8:  arc = 32'd3754917;
            4'd9:  arc = 32'd1877470;
            4'd10: arc = 32'd938734;
            4'd11: arc = 32'd469367;
            4'd12: arc = 32'd234684;
            4'd13: arc = 32'd117342;
            4'd14: arc = 32'd58671;
            4'd15: arc = 32'd29335;
        endcase
        return arc;
    endfunction

endpackage

### sv/cordic_rotate_vector_unit.sv
// top level: input setup, chain of cordic cells and post-processing
//
//   channel | valid   | stall   | payload
//   --------+---------+---------+---------------------------------------------
//   input   | i_valid | o_stall | i_kind, i_x_in, i_y_in, i_angle_deg
//   output  | o_valid | i_stall | o_first_out, o_second_out
//
// one transfer per cycle in each direction while the other side does not stall;
// the pipeline is the chain of cordic cells plus four post stages (reciprocal
// multiply, quotient correction, percent multiply, output register).
// reset is synchronous and clears only the stage valid bits.
// each stage stalls only when it is full and its successor stalls, so
// bubbles collapse and input keeps flowing while a result waits.
module cordic_rotate_vector_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [crv_pkg::KIND_W-1:0]          i_kind,
    input  logic signed [crv_pkg::COMP_W-1:0]   i_x_in,
    input  logic signed [crv_pkg::COMP_W-1:0]   i_y_in,
    input  logic signed [crv_pkg::ANGLE_W-1:0]  i_angle_deg,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [crv_pkg::COMP_W-1:0]   o_first_out,
    output logic signed [crv_pkg::COMP_W-1:0]   o_second_out
);

    crv_pkg::t_cordic_data  in_data;
    crv_pkg::t_kind         in_kind;
    logic                   c_valid [crv_pkg::ITER_COUNT+1];
    logic                   c_stall [crv_pkg::ITER_COUNT+1];
    crv_pkg::t_cordic_data  c_data  [crv_pkg::ITER_COUNT+1];

    // initial vector and residual angle per kind
    always_comb begin
        in_kind      = crv_pkg::t_kind'(i_kind);
        in_data.kind = in_kind;
        in_data.x    = crv_pkg::DATA_W'(i_x_in);
        in_data.y    = crv_pkg::DATA_W'(i_y_in);
        in_data.z    = crv_pkg::DATA_W'(i_angle_deg) << crv_pkg::ANGLE_SHIFT;
        unique case (in_kind)
            crv_pkg::KIND_TRIG: begin
                in_data.x = crv_pkg::UNIT_X;
                in_data.y = '0;
            end
            crv_pkg::KIND_VECTOR: begin
                in_data.z = '0;
            end
            crv_pkg::KIND_ROTATE, crv_pkg::KIND_NONE: begin
            end
            default: begin
            end
        endcase
    end

    assign c_valid[0] = i_valid;
    assign c_data[0]  = in_data;
    assign o_stall    = c_stall[0];

    // cell chain, one micro-rotation per cell
    for (genvar g = 0; g < crv_pkg::ITER_COUNT; g++) begin : g_cell
        crv_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_idx   (crv_pkg::IDX_W'(g)),
            .i_valid (c_valid[g]),
            .i_data  (c_data[g]),
            .o_stall (c_stall[g]),
            .o_valid (c_valid[g+1]),
            .o_data  (c_data[g+1]),
            .i_stall (c_stall[g+1])
        );
    end

    crv_post u_post (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (c_valid[crv_pkg::ITER_COUNT]),
        .i_data       (c_data[crv_pkg::ITER_COUNT]),
        .o_stall      (c_stall[crv_pkg::ITER_COUNT]),
        .o_valid      (o_valid),
        .o_first_out  (o_first_out),
        .o_second_out (o_second_out),
        .i_stall      (i_stall)
    );

    // reset empties the pipe
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    // input blocks only when the first cell holds an item
    a_stall_needs_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> c_valid[1])
        else $error("input stalled with first cell empty");

    // a free output register means nothing upstream may stall
    a_no_stall_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_valid || !i_stall) |-> !o_stall)
        else $error("input stalled while output is free");

    // the first cell holds its item across a stall
    a_first_cell_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        c_stall[0] |=> c_valid[1])
        else $error("first cell lost its item during a stall");

endmodule

### sv/crv_cell.sv
// one cordic micro-rotation stage with its own valid bit and stall
module crv_cell (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [crv_pkg::IDX_W-1:0]  i_idx,
    input  logic                       i_valid,
    input  crv_pkg::t_cordic_data      i_data,
    output logic                       o_stall,
    output logic                       o_valid,
    output crv_pkg::t_cordic_data      o_data,
    input  logic                       i_stall
);

    logic                          r_valid;
    crv_pkg::t_cordic_data         r_data;
    crv_pkg::t_cordic_data         n_data;
    logic                          flip;
    logic [crv_pkg::DATA_W-1:0]    arc;
    logic [crv_pkg::DATA_W-1:0]    mask;
    logic [crv_pkg::DATA_W-1:0]    bit_i;
    logic [crv_pkg::DATA_W-1:0]    rx;
    logic [crv_pkg::DATA_W-1:0]    ry;

    // micro-rotation with sticky rounding into bit i before the shift
    always_comb begin
        if (i_data.kind == crv_pkg::KIND_VECTOR) begin
            flip = !i_data.y[crv_pkg::DATA_W-1];
        end else begin
            flip = i_data.z[crv_pkg::DATA_W-1];
        end
        arc   = crv_pkg::atan_arc(i_idx);
        bit_i = crv_pkg::DATA_W'(1) << i_idx;
        if (i_idx >= crv_pkg::IDX_W'(2)) begin
            mask = (crv_pkg::DATA_W'(1) << (i_idx - crv_pkg::IDX_W'(1))) - crv_pkg::DATA_W'(1);
        end else begin
            mask = '0;
        end
        rx = flip ? (crv_pkg::DATA_W'(0) - i_data.x) : i_data.x;
        ry = flip ? (crv_pkg::DATA_W'(0) - i_data.y) : i_data.y;
        if ((mask & rx) != '0) begin
            rx = rx | bit_i;
        end
        if ((mask & ry) != '0) begin
            ry = ry | bit_i;
        end
        n_data.kind = i_data.kind;
        n_data.x    = i_data.x - crv_pkg::DATA_W'($signed(ry) >>> i_idx);
        n_data.y    = i_data.y + crv_pkg::DATA_W'($signed(rx) >>> i_idx);
        n_data.z    = i_data.z - (flip ? (crv_pkg::DATA_W'(0) - arc) : arc);
    end

    // hold while full and the next stage is stalled
    assign o_stall = r_valid & i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

### sv/crv_post.sv
// gain removal, angle extraction and percent scaling after the cell chain
module crv_post (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  crv_pkg::t_cordic_data             i_data,
    output logic                              o_stall,
    output logic                              o_valid,
    output logic signed [crv_pkg::COMP_W-1:0] o_first_out,
    output logic signed [crv_pkg::COMP_W-1:0] o_second_out,
    input  logic                              i_stall
);

    // stage 1: magnitudes times reciprocal, angle rounding
    logic                           r1_valid;
    crv_pkg::t_kind                 r1_kind;
    logic                           r1_sx;
    logic                           r1_sy;
    logic [crv_pkg::MAG_W-1:0]      r1_mx;
    logic [crv_pkg::MAG_W-1:0]      r1_my;
    logic [crv_pkg::PROD_W-1:0]     r1_px;
    logic [crv_pkg::PROD_W-1:0]     r1_py;
    logic [crv_pkg::COMP_W-1:0]     r1_ang;
    // stage 2: corrected quotients with sign applied
    logic                           r2_valid;
    crv_pkg::t_kind                 r2_kind;
    logic [crv_pkg::COMP_W-1:0]     r2_gx;
    logic [crv_pkg::COMP_W-1:0]     r2_gy;
    logic [crv_pkg::COMP_W-1:0]     r2_ang;
    // stage 3: percent products
    logic                           r3_valid;
    crv_pkg::t_kind                 r3_kind;
    logic [crv_pkg::COMP_W-1:0]     r3_gx;
    logic [crv_pkg::COMP_W-1:0]     r3_gy;
    logic [crv_pkg::COMP_W-1:0]     r3_ang;
    logic signed [crv_pkg::PCT_W-1:0] r3_pcx;
    logic signed [crv_pkg::PCT_W-1:0] r3_pcy;
    // output register
    logic                           r_out_valid;
    logic [crv_pkg::COMP_W-1:0]     r_first;
    logic [crv_pkg::COMP_W-1:0]     r_second;

    logic s1;
    logic s2;
    logic s3;
    logic s_out;

    logic [crv_pkg::DATA_W-1:0]     abs_x;
    logic [crv_pkg::DATA_W-1:0]     abs_y;
    logic [crv_pkg::DATA_W-1:0]     z_rnd;
    logic [crv_pkg::MAG_W-1:0]      qe_x;
    logic [crv_pkg::MAG_W-1:0]      qe_y;
    logic [crv_pkg::REM_W-1:0]      rem_x;
    logic [crv_pkg::REM_W-1:0]      rem_y;
    logic [crv_pkg::MAG_W-1:0]      q_x;
    logic [crv_pkg::MAG_W-1:0]      q_y;
    logic [crv_pkg::COMP_W-1:0]     n2_gx;
    logic [crv_pkg::COMP_W-1:0]     n2_gy;
    logic signed [crv_pkg::PCT_W-1:0] n3_pcx;
    logic signed [crv_pkg::PCT_W-1:0] n3_pcy;
    logic [crv_pkg::PCT_W-1:0]      pr_x;
    logic [crv_pkg::PCT_W-1:0]      pr_y;
    logic [crv_pkg::COMP_W-1:0]     pct_x;
    logic [crv_pkg::COMP_W-1:0]     pct_y;
    logic [crv_pkg::COMP_W-1:0]     n_first;
    logic [crv_pkg::COMP_W-1:0]     n_second;

    // stall chain: a stage holds only when full and blocked downstream
    assign s_out   = r_out_valid & i_stall;
    assign s3      = r3_valid & s_out;
    assign s2      = r2_valid & s3;
    assign s1      = r1_valid & s2;
    assign o_stall = s1;

    // stage 1 logic
    always_comb begin
        abs_x = i_data.x[crv_pkg::DATA_W-1] ? (crv_pkg::DATA_W'(0) - i_data.x) : i_data.x;
        abs_y = i_data.y[crv_pkg::DATA_W-1] ? (crv_pkg::DATA_W'(0) - i_data.y) : i_data.y;
        z_rnd = i_data.z;
        if (i_data.z[crv_pkg::ANGLE_SHIFT-2:0] != '0) begin
            z_rnd[crv_pkg::ANGLE_SHIFT] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (!s1) begin
            r1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!s1 && i_valid) begin
            r1_kind <= i_data.kind;
            r1_sx   <= i_data.x[crv_pkg::DATA_W-1];
            r1_sy   <= i_data.y[crv_pkg::DATA_W-1];
            r1_mx   <= abs_x[crv_pkg::MAG_W-1:0];
            r1_my   <= abs_y[crv_pkg::MAG_W-1:0];
            r1_px   <= crv_pkg::PROD_W'(abs_x[crv_pkg::MAG_W-1:0]) *
                       crv_pkg::PROD_W'(crv_pkg::GAIN_RECIP);
            r1_py   <= crv_pkg::PROD_W'(abs_y[crv_pkg::MAG_W-1:0]) *
                       crv_pkg::PROD_W'(crv_pkg::GAIN_RECIP);
            r1_ang  <= crv_pkg::COMP_W'($signed(z_rnd[crv_pkg::DATA_W-1:crv_pkg::ANGLE_SHIFT]));
        end
    end

    // stage 2: estimate is low by at most one, fix with a remainder compare
    always_comb begin
        qe_x  = r1_px[crv_pkg::GAIN_SHIFT +: crv_pkg::MAG_W];
        qe_y  = r1_py[crv_pkg::GAIN_SHIFT +: crv_pkg::MAG_W];
        rem_x = (crv_pkg::REM_W'(r1_mx) << crv_pkg::GAIN_PRESCALE) -
                crv_pkg::REM_W'(qe_x) * crv_pkg::REM_W'(crv_pkg::GAIN_DIV);
        rem_y = (crv_pkg::REM_W'(r1_my) << crv_pkg::GAIN_PRESCALE) -
                crv_pkg::REM_W'(qe_y) * crv_pkg::REM_W'(crv_pkg::GAIN_DIV);
        q_x   = (rem_x >= crv_pkg::REM_W'(crv_pkg::GAIN_DIV)) ?
                (qe_x + crv_pkg::MAG_W'(1)) : qe_x;
        q_y   = (rem_y >= crv_pkg::REM_W'(crv_pkg::GAIN_DIV)) ?
                (qe_y + crv_pkg::MAG_W'(1)) : qe_y;
        // truncation toward zero, then wrap to 16 bits
        n2_gx = r1_sx ? (crv_pkg::COMP_W'(0) - q_x[crv_pkg::COMP_W-1:0]) :
                q_x[crv_pkg::COMP_W-1:0];
        n2_gy = r1_sy ? (crv_pkg::COMP_W'(0) - q_y[crv_pkg::COMP_W-1:0]) :
                q_y[crv_pkg::COMP_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (!s2) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!s2 && r1_valid) begin
            r2_kind <= r1_kind;
            r2_gx   <= n2_gx;
            r2_gy   <= n2_gy;
            r2_ang  <= r1_ang;
        end
    end

    // stage 3: scale by 100
    always_comb begin
        n3_pcx = crv_pkg::PCT_W'($signed(r2_gx) *
                 $signed(crv_pkg::PCT_K_W'(crv_pkg::PCT_SCALE)));
        n3_pcy = crv_pkg::PCT_W'($signed(r2_gy) *
                 $signed(crv_pkg::PCT_K_W'(crv_pkg::PCT_SCALE)));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (!s3) begin
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!s3 && r2_valid) begin
            r3_kind <= r2_kind;
            r3_gx   <= r2_gx;
            r3_gy   <= r2_gy;
            r3_ang  <= r2_ang;
            r3_pcx  <= n3_pcx;
            r3_pcy  <= n3_pcy;
        end
    end

    // percent rounding and result select
    always_comb begin
        pr_x = r3_pcx;
        pr_y = r3_pcy;
        if (pr_x[crv_pkg::PCT_SHIFT-1:0] != '0) begin
            pr_x[crv_pkg::PCT_SHIFT] = 1'b1;
        end
        if (pr_y[crv_pkg::PCT_SHIFT-1:0] != '0) begin
            pr_y[crv_pkg::PCT_SHIFT] = 1'b1;
        end
        pct_x = crv_pkg::COMP_W'($signed(pr_x[crv_pkg::PCT_W-1:crv_pkg::PCT_SHIFT]));
        pct_y = crv_pkg::COMP_W'($signed(pr_y[crv_pkg::PCT_W-1:crv_pkg::PCT_SHIFT]));
        unique case (r3_kind)
            crv_pkg::KIND_ROTATE: begin
                n_first  = r3_gx;
                n_second = r3_gy;
            end
            crv_pkg::KIND_VECTOR: begin
                n_first  = r3_gx;
                n_second = r3_ang;
            end
            crv_pkg::KIND_TRIG: begin
                n_first  = pct_x;
                n_second = pct_y;
            end
            crv_pkg::KIND_NONE: begin
                n_first  = '0;
                n_second = '0;
            end
            default: begin
                n_first  = '0;
                n_second = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!s_out) begin
            r_out_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!s_out && r3_valid) begin
            r_first  <= n_first;
            r_second <= n_second;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_first_out  = r_first;
    assign o_second_out = r_second;

endmodule

### bench/tb_top.sv
// self-checking bench for the cordic rotate/vector unit: bursty random traffic against a predictor
`timescale 1ns / 1ps

module tb_top;

    localparam int CLK_HALF    = 5;
    localparam int RESET_CYC   = 11;
    localparam int PIPE_DEPTH  = crv_pkg::ITER_COUNT + 4;
    localparam int RANDOM_ITEMS = 600;
    localparam int CYCLE_LIMIT = 400000;

    // arctan(2^-i) in degrees, scaled by 2^24
    localparam logic [31:0] ARCTAN_DEG [16] = '{
        32'd754974720, 32'd445687602, 32'd235489088, 32'd119537938,
        32'd60000934,  32'd30029717,  32'd15018523,  32'd7509720,
        32'd3754917,   32'd1877470,   32'd938734,    32'd469367,
        32'd234684,    32'd117342,    32'd58671,     32'd29335
    };

    typedef enum logic [1:0] {
        RX_FLOW,
        RX_LIGHT,
        RX_HEAVY,
        RX_PERIODIC
    } t_rx_mode;

    typedef struct {
        logic signed [crv_pkg::COMP_W-1:0] first;
        logic signed [crv_pkg::COMP_W-1:0] second;
    } t_cordic_result;

    // expected results in arrival order plus the predictor that makes them
    class cordic_scoreboard;
        t_cordic_result pending_results[$];
        int             mismatch_count;

        function new();
            mismatch_count = 0;
        endfunction

        function logic [31:0] sra32(logic [31:0] v, int s);
            return $signed(v) >>> s;
        endfunction

        // 16 micro-rotations with the sticky rounding ahead of each shift
        function void micro_rotate(inout logic [31:0] x, inout logic [31:0] y,
                                   inout logic [31:0] z, input bit vectoring);
            logic [31:0] arc;
            logic [31:0] rx;
            logic [31:0] ry;
            logic [31:0] mask;
            bit          flip;
            for (int i = 0; i < 16; i++) begin
                arc  = ARCTAN_DEG[i];
                rx   = x;
                ry   = y;
                mask = (i >= 2) ? ((32'd1 << (i - 1)) - 32'd1) : 32'd0;
                flip = vectoring ? !y[31] : z[31];
                if (flip) begin
                    arc = -arc;
                    rx  = -rx;
                    ry  = -ry;
                end
                if ((mask & rx) != 0) rx[i] = 1'b1;
                if ((mask & ry) != 0) ry[i] = 1'b1;
                x = x - sra32(ry, i);
                y = y + sra32(rx, i);
                z = z - arc;
            end
        endfunction

        // divide out the cordic gain, truncating toward zero
        function logic [15:0] strip_gain(logic [31:0] v);
            longint q;
            q = (longint'($signed(v)) * 1024) / 1686;
            return q[15:0];
        endfunction

        // component times 100 over 2^14 with sticky rounding
        function logic [15:0] percent_of(logic [15:0] c);
            logic [31:0] v;
            logic [31:0] t;
            v = {{16{c[15]}}, c} * 32'd100;
            if (v[13:0] != 0) v[14] = 1'b1;
            t = sra32(v, 14);
            return t[15:0];
        endfunction

        function t_cordic_result predict(crv_pkg::t_kind kind, logic [15:0] x_in,
                                         logic [15:0] y_in, logic [7:0] ang);
            t_cordic_result r;
            logic [31:0]    px;
            logic [31:0]    py;
            logic [31:0]    pz;
            logic [31:0]    t;
            px = {{16{x_in[15]}}, x_in};
            py = {{16{y_in[15]}}, y_in};
            r.first  = '0;
            r.second = '0;
            case (kind)
                crv_pkg::KIND_ROTATE, crv_pkg::KIND_TRIG: begin
                    if (kind == crv_pkg::KIND_TRIG) begin
                        px = 32'd16384;
                        py = 32'd0;
                    end
                    pz = {ang, 24'd0};
                    micro_rotate(px, py, pz, 1'b0);
                    r.first  = strip_gain(px);
                    r.second = strip_gain(py);
                    if (kind == crv_pkg::KIND_TRIG) begin
                        r.first  = percent_of(r.first);
                        r.second = percent_of(r.second);
                    end
                end
                crv_pkg::KIND_VECTOR: begin
                    pz = '0;
                    micro_rotate(px, py, pz, 1'b1);
                    r.first = strip_gain(px);
                    // leftover fraction rounds the angle away from truncation
                    if (pz[22:0] != 0) pz[24] = 1'b1;
                    t = sra32(pz, 24);
                    r.second = t[15:0];
                end
                default: begin
                    r.first  = '0;
                    r.second = '0;
                end
            endcase
            return r;
        endfunction

        function void note_input(crv_pkg::t_kind kind, logic [15:0] x_in,
                                 logic [15:0] y_in, logic [7:0] ang);
            pending_results.push_back(predict(kind, x_in, y_in, ang));
        endfunction

        task report_mismatch(string what);
            $display("[%0t] mismatch: %s", $realtime, what);
            mismatch_count++;
        endtask

        task check_result(logic signed [15:0] first, logic signed [15:0] second);
            t_cordic_result exp_r;
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result %0d %0d", first, second));
            end else begin
                exp_r = pending_results.pop_front();
                if (first !== exp_r.first)
                    report_mismatch($sformatf("first_out %0d, expected %0d",
                                              first, exp_r.first));
                if (second !== exp_r.second)
                    report_mismatch($sformatf("second_out %0d, expected %0d",
                                              second, exp_r.second));
            end
        endtask
    endclass

    logic                               i_clk;
    logic                               i_rst_n;
    logic                               i_valid;
    logic                               o_stall;
    crv_pkg::t_kind                     i_kind;
    logic signed [crv_pkg::COMP_W-1:0]  i_x_in;
    logic signed [crv_pkg::COMP_W-1:0]  i_y_in;
    logic signed [crv_pkg::ANGLE_W-1:0] i_angle_deg;
    logic                               o_valid;
    logic                               i_stall;
    logic signed [crv_pkg::COMP_W-1:0]  o_first_out;
    logic signed [crv_pkg::COMP_W-1:0]  o_second_out;

    cordic_scoreboard sb;
    int unsigned      cycle_count;
    t_rx_mode         rx_mode;
    int unsigned      rx_left;
    int unsigned      rx_tick;

    cordic_rotate_vector_unit dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_kind       (i_kind),
        .i_x_in       (i_x_in),
        .i_y_in       (i_y_in),
        .i_angle_deg  (i_angle_deg),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_first_out  (o_first_out),
        .o_second_out (o_second_out)
    );

    // clock
    initial i_clk = 1'b0;
    always #CLK_HALF i_clk = ~i_clk;

    // watchdog
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // monitor: note each input transfer, check each output transfer
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall)
            sb.note_input(i_kind, i_x_in, i_y_in, i_angle_deg);
        if (i_rst_n && o_valid && !i_stall)
            sb.check_result(o_first_out, o_second_out);
    end

    // receiver stall pattern, switching to a random mode after a random run length
    initial begin
        rx_mode = RX_FLOW;
        rx_left = 40;
        rx_tick = 0;
        i_stall = 1'b0;
    end
    always @(negedge i_clk) begin
        rx_tick <= rx_tick + 1;
        if (rx_left == 0) begin
            rx_mode <= t_rx_mode'($urandom_range(0, 3));
            rx_left <= $urandom_range(20, 150);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            RX_FLOW:     i_stall <= 1'b0;
            RX_LIGHT:    i_stall <= ($urandom_range(0, 99) < 30);
            RX_HEAVY:    i_stall <= ($urandom_range(0, 99) < 85);
            RX_PERIODIC: i_stall <= ((rx_tick % 7) < 3);
            default:     i_stall <= 1'b0;
        endcase
    end

    // hold one item on the input until it transfers
    task send_item(input crv_pkg::t_kind kind, input logic [15:0] x_in,
                   input logic [15:0] y_in, input logic [7:0] ang);
        @(negedge i_clk);
        i_valid     <= 1'b1;
        i_kind      <= kind;
        i_x_in      <= x_in;
        i_y_in      <= y_in;
        i_angle_deg <= ang;
        do begin
            @(posedge i_clk);
        end while (o_stall);
    endtask

    task idle_input(input int n);
        @(negedge i_clk);
        i_valid <= 1'b0;
        repeat (n - 1) @(negedge i_clk);
    endtask

    // component: mostly full range, some small values and some extremes
    function logic [15:0] random_component();
        int r;
        r = $urandom_range(0, 15);
        if (r < 2) return 16'($urandom_range(0, 200) - 100);
        if (r == 2) return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
        return 16'($urandom());
    endfunction

    task random_traffic(input int n);
        int             sent;
        int             burst;
        int             r;
        int             gap;
        crv_pkg::t_kind kind;
        logic [7:0]     ang;
        sent = 0;
        while (sent < n) begin
            burst = $urandom_range(1, 24);
            for (int j = 0; j < burst && sent < n; j++) begin
                r = $urandom_range(0, 19);
                if (r < 7)       kind = crv_pkg::KIND_ROTATE;
                else if (r < 13) kind = crv_pkg::KIND_VECTOR;
                else if (r < 18) kind = crv_pkg::KIND_TRIG;
                else             kind = crv_pkg::KIND_NONE;
                if ($urandom_range(0, 99) < 85) ang = 8'($urandom_range(0, 180) - 90);
                else                            ang = 8'($urandom());
                send_item(kind, random_component(), random_component(), ang);
                sent++;
            end
            r = $urandom_range(0, 9);
            if (r < 4)      gap = 0;
            else if (r < 8) gap = $urandom_range(1, 4);
            else if (r < 9) gap = $urandom_range(5, 12);
            else            gap = $urandom_range(20, 40);
            if (gap > 0) idle_input(gap);
        end
    endtask

    initial begin
        sb          = new();
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_kind      = crv_pkg::KIND_ROTATE;
        i_x_in      = '0;
        i_y_in      = '0;
        i_angle_deg = '0;
        repeat (RESET_CYC) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: field extremes, every kind, exact and fractional angles
        send_item(crv_pkg::KIND_ROTATE, 16'h7fff, 16'h7fff, 8'd90);
        send_item(crv_pkg::KIND_ROTATE, 16'h8000, 16'h8000, -8'sd90);
        send_item(crv_pkg::KIND_ROTATE, 16'h7fff, 16'h8000, 8'd0);
        send_item(crv_pkg::KIND_ROTATE, 16'h8000, 16'h7fff, 8'h7f);
        send_item(crv_pkg::KIND_ROTATE, 16'd1000, 16'd0, 8'h80);
        send_item(crv_pkg::KIND_ROTATE, 16'd0, 16'd0, 8'd45);
        send_item(crv_pkg::KIND_VECTOR, 16'd0, 16'd0, 8'd0);
        send_item(crv_pkg::KIND_VECTOR, 16'h7fff, 16'h7fff, 8'hff);
        send_item(crv_pkg::KIND_VECTOR, 16'h8000, 16'h8000, 8'd0);
        send_item(crv_pkg::KIND_VECTOR, 16'd3, 16'd4, 8'd0);
        send_item(crv_pkg::KIND_VECTOR, 16'd1000, 16'd0, 8'd0);
        send_item(crv_pkg::KIND_VECTOR, -16'sd1000, 16'd1, 8'd0);
        send_item(crv_pkg::KIND_VECTOR, 16'h7fff, 16'h8000, 8'd0);
        send_item(crv_pkg::KIND_VECTOR, 16'd1, 16'hffff, 8'd0);
        send_item(crv_pkg::KIND_TRIG, 16'd0, 16'd0, 8'd0);
        send_item(crv_pkg::KIND_TRIG, 16'hffff, 16'hffff, 8'd90);
        send_item(crv_pkg::KIND_TRIG, 16'd0, 16'd0, -8'sd90);
        send_item(crv_pkg::KIND_TRIG, 16'd0, 16'd0, 8'd45);
        send_item(crv_pkg::KIND_TRIG, 16'd0, 16'd0, 8'h7f);
        send_item(crv_pkg::KIND_TRIG, 16'd0, 16'd0, 8'h80);
        send_item(crv_pkg::KIND_NONE, 16'hffff, 16'hffff, 8'hff);
        send_item(crv_pkg::KIND_NONE, 16'd0, 16'd0, 8'd0);
        idle_input($urandom_range(1, 8));

        random_traffic(RANDOM_ITEMS);
        idle_input(1);

        // drain, then watch for stray results
        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (2 * PIPE_DEPTH) @(posedge i_clk);

        if (sb.mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
